>>> hdl/vcsh_pkg.sv
// Shared types and constants for the column voxel store with height map.
// Used by the controller, the datapath and the top level.
package vcsh_pkg;

  // Default geometry and cell width.
  localparam int MIN_Y_DEF         = -64;
  localparam int SECTION_COUNT_DEF = 24;
  localparam int STATE_BITS_DEF    = 16;

  typedef enum logic [2:0] {
    CMD_READ_CELL    = 3'd0,
    CMD_WRITE_DIRTY  = 3'd1,
    CMD_WRITE_SILENT = 3'd2,
    CMD_READ_HEIGHT  = 3'd3,
    CMD_CLEAR_DIRTY  = 3'd4
  } cmd_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EXEC  = 5'b01000,
    ST_SCAN  = 5'b10000
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;   // clearing sweep, one cell per cycle
    logic load;    // capture a new command beat
    logic read;    // read cell and column height
    logic exec;    // decide, write back
    logic scan;    // downward search for the new column top
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
    logic need_scan;
    logic scan_done;
  } sts_t;

endpackage

>>> hdl/vcsh_ctrl.sv
// Sequencer for the voxel store: clearing sweep, read, execute and scan steps.
// Depends on vcsh_pkg for state, command and status types.
module vcsh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  vcsh_pkg::sts_t sts,
  output vcsh_pkg::ctl_t ctl,
  output logic          busy
);
  import vcsh_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    busy       = 1'b1;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
        if (start) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        ctl.read   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.need_scan) begin
          state_next = ST_SCAN;
        end else begin
          // result leaves this cycle: take the next beat right away
          busy       = 1'b0;
          ctl.load   = start;
          state_next = start ? ST_READ : ST_IDLE;
        end
      end
      ST_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> hdl/vcsh_datapath.sv
// Datapath of the voxel store: cell memory, height memory, dirty flag, result registers.
// Depends on vcsh_pkg for command codes and the control/status structs.
module vcsh_datapath #(
  parameter int MIN_Y         = vcsh_pkg::MIN_Y_DEF,
  parameter int SECTION_COUNT = vcsh_pkg::SECTION_COUNT_DEF,
  parameter int STATE_BITS    = vcsh_pkg::STATE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  vcsh_pkg::ctl_t     ctl,
  output vcsh_pkg::sts_t     sts,
  input  logic [2:0]         cmd,
  input  logic [3:0]         x,
  input  logic [3:0]         z,
  input  logic signed [11:0] y,
  input  logic [15:0]        state_id,
  output logic               done,
  output logic [15:0]        cell_value,
  output logic signed [12:0] column_height,
  output logic               changed,
  output logic               mesh_dirty
);
  import vcsh_pkg::*;

  localparam int COLUMN_CELLS = SECTION_COUNT * 16;
  localparam int STORE_CELLS  = COLUMN_CELLS * 256;
  localparam int OFFW         = $clog2(COLUMN_CELLS);
  localparam int ADDR_W       = OFFW + 8;
  localparam int HW           = $clog2(COLUMN_CELLS + 1);

  localparam logic signed [12:0] MIN_Y13   = 13'(MIN_Y);
  localparam logic signed [12:0] HBASE     = 13'(MIN_Y - 1);
  localparam logic [12:0]        COL_LIMIT = 13'(COLUMN_CELLS);
  localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(STORE_CELLS - 1);

  // Heights are kept as offset + 1 above the store floor; zero means an all-air column.
  logic [STATE_BITS-1:0] cells [STORE_CELLS];
  logic [HW-1:0]         heights [256];

  logic [2:0]            cmd_q;
  logic [3:0]            x_q;
  logic [3:0]            z_q;
  logic signed [12:0]    off_q;
  logic [STATE_BITS-1:0] val_q;

  logic [ADDR_W-1:0]     clr_cnt;
  logic [STATE_BITS-1:0] cell_rd;
  logic [HW-1:0]         h_rd;
  logic                  dirty;
  logic                  dirty_next;

  logic [OFFW-1:0]       scan_off;
  logic [OFFW-1:0]       probe_off;
  logic                  probe_valid;

  logic [7:0]            col;
  logic [ADDR_W-1:0]     cell_addr;
  logic [ADDR_W-1:0]     scan_addr;
  logic                  in_store;
  logic                  is_write;
  logic                  wrote;
  logic                  need_scan;
  logic [HW-1:0]         off1;
  logic [HW-1:0]         h_exec;
  logic [HW-1:0]         h_scan;
  logic                  scan_done;
  logic                  finish_exec;
  logic                  finish_scan;
  logic [STATE_BITS-1:0] res_exec;

  logic                  cell_we;
  logic [ADDR_W-1:0]     cell_wa;
  logic [STATE_BITS-1:0] cell_wd;
  logic                  cell_re;
  logic [ADDR_W-1:0]     cell_ra;
  logic                  h_we;
  logic [7:0]            h_wa;
  logic [HW-1:0]         h_wd;

  assign col       = {z_q, x_q};
  assign cell_addr = {off_q[OFFW-1:0], z_q, x_q};
  assign scan_addr = {scan_off, z_q, x_q};
  assign in_store  = !off_q[12] && ($unsigned(off_q) < COL_LIMIT);
  assign is_write  = (cmd_q == CMD_WRITE_DIRTY) || (cmd_q == CMD_WRITE_SILENT);
  assign wrote     = is_write && in_store && (cell_rd != val_q);
  assign off1      = HW'(off_q[OFFW-1:0]) + HW'(1);

  // Clearing the column top with cells below it needs the downward search.
  assign need_scan = wrote && (val_q == '0) && (h_rd == off1) && (off_q[OFFW-1:0] != '0);

  always_comb begin
    h_exec = h_rd;
    if (wrote) begin
      if (val_q != '0) begin
        h_exec = (off1 > h_rd) ? off1 : h_rd;
      end else if (h_rd == off1) begin
        h_exec = '0;   // bottom cell was the top: column now all air
      end
    end
  end

  assign res_exec = wrote ? val_q : (in_store ? cell_rd : '0);

  always_comb begin
    dirty_next = dirty;
    if (ctl.exec) begin
      if (cmd_q == CMD_CLEAR_DIRTY) begin
        dirty_next = 1'b0;
      end else if (cmd_q == CMD_WRITE_DIRTY && wrote) begin
        dirty_next = 1'b1;
      end
    end
  end

  // Probe results arrive in the cycle after their read.
  always_comb begin
    scan_done = 1'b0;
    h_scan    = '0;
    if (probe_valid && cell_rd != '0) begin
      scan_done = 1'b1;
      h_scan    = HW'(probe_off) + HW'(1);
    end else if (probe_valid && probe_off == '0) begin
      scan_done = 1'b1;
    end
  end

  assign finish_exec = ctl.exec && !need_scan;
  assign finish_scan = ctl.scan && scan_done;

  assign sts.clear_last = (clr_cnt == LAST_ADDR);
  assign sts.need_scan  = need_scan;
  assign sts.scan_done  = scan_done;

  // Memory port muxing.
  assign cell_we = ctl.clear || (ctl.exec && wrote);
  assign cell_wa = ctl.clear ? clr_cnt : cell_addr;
  assign cell_wd = ctl.clear ? '0 : val_q;
  assign cell_re = ctl.read || ctl.scan;
  assign cell_ra = ctl.scan ? scan_addr : cell_addr;
  assign h_we    = ctl.clear || finish_exec || finish_scan;
  assign h_wa    = ctl.clear ? clr_cnt[7:0] : col;
  assign h_wd    = ctl.clear ? '0 : (ctl.exec ? h_exec : h_scan);

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cells[cell_wa] <= cell_wd;
    end
    if (cell_re) begin
      cell_rd <= cells[cell_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      heights[h_wa] <= h_wd;
    end
    if (ctl.read) begin
      h_rd <= heights[col];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd;
      x_q   <= x;
      z_q   <= z;
      off_q <= $signed({y[11], y}) - MIN_Y13;
      val_q <= STATE_BITS'(state_id);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      scan_off    <= off_q[OFFW-1:0] - OFFW'(1);
      probe_valid <= 1'b0;
    end else if (ctl.scan && !scan_done) begin
      probe_off   <= scan_off;
      probe_valid <= 1'b1;
      // hold at the floor; the last probe ends the search
      if (scan_off != '0) begin
        scan_off <= scan_off - OFFW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      dirty   <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (ctl.clear) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      dirty <= dirty_next;
      done  <= finish_exec || finish_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_exec || finish_scan) begin
      cell_value    <= finish_exec ? 16'(res_exec) : '0;
      column_height <= HBASE + 13'(finish_exec ? h_exec : h_scan);
      changed       <= finish_exec ? wrote : 1'b1;
      mesh_dirty    <= dirty_next;
    end
  end

endmodule

>>> hdl/voxel_column_store_heightmap.sv
// Top level of the column voxel store with per-column height map.
// Instantiates vcsh_ctrl and vcsh_datapath; types from vcsh_pkg.
//
// After reset the block sweeps its cell and height memories clear, one cell per cycle,
// through all SECTION_COUNT*4096 cells (98304 by default), with busy high. A command
// beat is taken when start is high and busy is low. Reads, height reads, flag clears and
// most writes pass through a read step (the cell and the column height are read) and an
// execute step (the write back); the next beat can be taken in the execute step. Writing
// air over a column top that has cells below it searches downward through the cell
// memory's read port, one cell per cycle, and busy stays high until the search ends.
// Each result appears on the result ports in the cycle after its item ends, flagged by
// done for exactly one cycle; the receiver has no way to hold it off.
module voxel_column_store_heightmap #(
  parameter int MIN_Y         = vcsh_pkg::MIN_Y_DEF,
  parameter int SECTION_COUNT = vcsh_pkg::SECTION_COUNT_DEF,
  parameter int STATE_BITS    = vcsh_pkg::STATE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic [3:0]         x,
  input  logic [3:0]         z,
  input  logic signed [11:0] y,
  input  logic [15:0]        state_id,
  output logic               done,
  output logic [15:0]        cell_value,
  output logic signed [12:0] column_height,
  output logic               changed,
  output logic               mesh_dirty
);
  import vcsh_pkg::*;

  ctl_t ctl;
  sts_t sts;

  vcsh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  vcsh_datapath #(
    .MIN_Y         (MIN_Y),
    .SECTION_COUNT (SECTION_COUNT),
    .STATE_BITS    (STATE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cmd           (cmd),
    .x             (x),
    .z             (z),
    .y             (y),
    .state_id      (state_id),
    .done          (done),
    .cell_value    (cell_value),
    .column_height (column_height),
    .changed       (changed),
    .mesh_dirty    (mesh_dirty)
  );

endmodule

>>> hdl/vcsh_check.sv
// Port-level checks for voxel_column_store_heightmap, attached with bind.
// Sees only the top-level ports and geometry parameters.
module vcsh_check #(
  parameter int MIN_Y         = vcsh_pkg::MIN_Y_DEF,
  parameter int SECTION_COUNT = vcsh_pkg::SECTION_COUNT_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [12:0] column_height
);

  localparam logic signed [13:0] H_LO = 14'(MIN_Y - 1);
  localparam logic signed [13:0] H_HI = 14'(MIN_Y + SECTION_COUNT * 16 - 1);

  // no stray result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // an accepted beat keeps the block busy for its read cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after accepting a beat");

  // every item passes through a read step before its result, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back-to-back result strobes");

  a_height_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed({column_height[12], column_height}) >= H_LO &&
              $signed({column_height[12], column_height}) <= H_HI))
    else $error("column height out of range");

endmodule

bind voxel_column_store_heightmap vcsh_check #(
  .MIN_Y         (MIN_Y),
  .SECTION_COUNT (SECTION_COUNT)
) u_vcsh_check (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .column_height (column_height)
);

>>> dv/voxel_result_checker.sv
// Checker for the column voxel store: watches the command and result channels,
// predicts every result and compares it field by field. Depends on vcsh_pkg.
module voxel_result_checker #(
  parameter int MIN_Y         = vcsh_pkg::MIN_Y_DEF,
  parameter int SECTION_COUNT = vcsh_pkg::SECTION_COUNT_DEF,
  parameter int STATE_BITS    = vcsh_pkg::STATE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         cmd,
  input  logic [3:0]         x,
  input  logic [3:0]         z,
  input  logic signed [11:0] y,
  input  logic [15:0]        state_id,
  input  logic               done,
  input  logic [15:0]        cell_value,
  input  logic signed [12:0] column_height,
  input  logic               changed,
  input  logic               mesh_dirty,
  output int                 mismatch_count,
  output int                 pending_beats
);
  timeunit 1ns;
  timeprecision 1ps;
  import vcsh_pkg::*;

  localparam int COLUMN_CELLS = SECTION_COUNT * 16;
  localparam int CELL_COUNT   = COLUMN_CELLS * 256;
  localparam int EMPTY_TOP    = MIN_Y - 1;
  localparam logic [15:0] STATE_MASK =
    (STATE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << STATE_BITS) - 32'd1);

  typedef struct packed {
    logic [15:0]        cell_value;
    logic signed [12:0] column_height;
    logic               changed;
    logic               mesh_dirty;
  } voxel_result_t;

  logic [15:0]   cells [CELL_COUNT];
  int            col_top [256];
  logic          dirty;
  voxel_result_t expected_results [$];
  voxel_result_t head;
  int            fails;
  int            i;

  function automatic bit in_store(int wy);
    return wy >= MIN_Y && wy < MIN_Y + COLUMN_CELLS;
  endfunction

  function automatic int cell_addr(int col, int wy);
    return (wy - MIN_Y) * 256 + col;
  endfunction

  function automatic logic [15:0] cell_at(int col, int wy);
    if (!in_store(wy)) return '0;
    return cells[cell_addr(col, wy)];
  endfunction

  // Write one cell and keep the column top current; returns whether the store changed.
  function automatic bit store_cell(int col, int wy, logic [15:0] val);
    int yy;
    if (!in_store(wy)) return 1'b0;
    if (cells[cell_addr(col, wy)] == val) return 1'b0;
    cells[cell_addr(col, wy)] = val;
    if (val != '0) begin
      if (wy > col_top[col]) col_top[col] = wy;
      return 1'b1;
    end
    if (col_top[col] != wy) return 1'b1;
    // top went to air: search downward for the next solid cell
    yy = wy - 1;
    while (yy >= MIN_Y && cells[cell_addr(col, yy)] == '0) yy--;
    col_top[col] = (yy >= MIN_Y) ? yy : EMPTY_TOP;
    return 1'b1;
  endfunction

  function automatic voxel_result_t apply_voxel_cmd(logic [2:0] op, logic [3:0] cx,
                                                    logic [3:0] cz, logic signed [11:0] cy,
                                                    logic [15:0] sid);
    voxel_result_t r;
    int            col;
    int            wy;
    bit            hit;
    col = int'(cz) * 16 + int'(cx);
    wy  = int'(cy);
    hit = 1'b0;
    case (op)
      CMD_WRITE_DIRTY: begin
        hit = store_cell(col, wy, sid & STATE_MASK);
        if (hit) dirty = 1'b1;
      end
      CMD_WRITE_SILENT: hit = store_cell(col, wy, sid & STATE_MASK);
      CMD_CLEAR_DIRTY:  dirty = 1'b0;
      default: ;
    endcase
    r.cell_value    = cell_at(col, wy);
    r.column_height = 13'(col_top[col]);
    r.changed       = hit;
    r.mesh_dirty    = dirty;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (i = 0; i < CELL_COUNT; i++) cells[i] = '0;
      for (i = 0; i < 256; i++) col_top[i] = EMPTY_TOP;
      dirty = 1'b0;
      fails = 0;
      expected_results.delete();
    end else begin
      // retire the result beat first; it always belongs to an earlier command
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command outstanding");
          fails++;
        end else begin
          head = expected_results.pop_front();
          if (cell_value !== head.cell_value) begin
            $error("cell_value: expected %0d, actual %0d", head.cell_value, cell_value);
            fails++;
          end
          if (column_height !== head.column_height) begin
            $error("column_height: expected %0d, actual %0d",
                   head.column_height, column_height);
            fails++;
          end
          if (changed !== head.changed) begin
            $error("changed: expected %0d, actual %0d", head.changed, changed);
            fails++;
          end
          if (mesh_dirty !== head.mesh_dirty) begin
            $error("mesh_dirty: expected %0d, actual %0d", head.mesh_dirty, mesh_dirty);
            fails++;
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_voxel_cmd(cmd, x, z, y, state_id));
    end
    mismatch_count <= fails;
    pending_beats  <= expected_results.size();
  end

endmodule

>>> dv/tb_top.sv
// Testbench top for the column voxel store: clock, reset, directed and random
// command beats. Depends on vcsh_pkg, voxel_result_checker and the block itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vcsh_pkg::*;

  localparam int MIN_Y        = MIN_Y_DEF;
  localparam int COLUMN_CELLS = SECTION_COUNT_DEF * 16;
  localparam int TOP_Y        = MIN_Y + COLUMN_CELLS - 1;
  localparam int RANDOM_BEATS = 550;
  localparam int DRAIN_CYCLES = 16;
  localparam int WAIT_LIMIT   = 20000;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         cmd;
  logic [3:0]         x;
  logic [3:0]         z;
  logic signed [11:0] y;
  logic [15:0]        state_id;
  logic               done;
  logic [15:0]        cell_value;
  logic signed [12:0] column_height;
  logic               changed;
  logic               mesh_dirty;
  int                 mismatch_count;
  int                 pending_beats;

  logic [3:0] hot_x [3];
  logic [3:0] hot_z [3];
  logic [2:0] op;
  logic [3:0] cx;
  logic [3:0] cz;
  logic [15:0] sid;
  int         cy;
  int         gap;
  int         roll;
  int         n;
  int         waited;

  always #10 clk = ~clk;

  voxel_column_store_heightmap u_top (
    .clk, .rst, .start, .busy, .cmd, .x, .z, .y, .state_id,
    .done, .cell_value, .column_height, .changed, .mesh_dirty
  );

  voxel_result_checker u_chk (
    .clk, .rst, .start, .busy, .cmd, .x, .z, .y, .state_id,
    .done, .cell_value, .column_height, .changed, .mesh_dirty,
    .mismatch_count, .pending_beats
  );

  // Idle through the requested gap with noise on the fields, then hold the beat until taken.
  task automatic send_beat(input logic [2:0] c, input logic [3:0] bx, input logic [3:0] bz,
                           input int by, input logic [15:0] bs, input int g);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) begin
        cmd      <= 3'($urandom);
        x        <= 4'($urandom);
        z        <= 4'($urandom);
        y        <= 12'($urandom);
        state_id <= 16'($urandom);
        @(posedge clk);
      end
    end
    cmd      <= c;
    x        <= bx;
    z        <= bz;
    y        <= 12'(by);
    state_id <= bs;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    start    <= 1'b0;
    cmd      <= CMD_READ_CELL;
    x        <= '0;
    z        <= '0;
    y        <= '0;
    state_id <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: corners, every command, top removal with and without a lower cell
    send_beat(CMD_READ_CELL,    4'd0,  4'd0,  MIN_Y,     16'h0000, 0);
    send_beat(CMD_READ_HEIGHT,  4'd15, 4'd15, TOP_Y,     16'h0000, 0);
    send_beat(CMD_WRITE_DIRTY,  4'd3,  4'd5,  MIN_Y,     16'hFFFF, 0);
    send_beat(CMD_WRITE_DIRTY,  4'd3,  4'd5,  MIN_Y,     16'hFFFF, 0);
    send_beat(CMD_CLEAR_DIRTY,  4'd3,  4'd5,  MIN_Y,     16'h0000, 0);
    send_beat(CMD_WRITE_SILENT, 4'd3,  4'd5,  10,        16'h1234, 0);
    send_beat(CMD_WRITE_SILENT, 4'd3,  4'd5,  0,         16'h0007, 0);
    send_beat(CMD_WRITE_DIRTY,  4'd3,  4'd5,  MIN_Y,     16'h0000, 0);
    send_beat(CMD_WRITE_DIRTY,  4'd3,  4'd5,  10,        16'h0000, 0);
    send_beat(CMD_WRITE_SILENT, 4'd3,  4'd5,  0,         16'h0000, 0);
    send_beat(CMD_WRITE_DIRTY,  4'd3,  4'd5,  20,        16'h0000, 0);
    send_beat(CMD_WRITE_DIRTY,  4'd15, 4'd15, TOP_Y,     16'h8000, 0);
    send_beat(CMD_READ_CELL,    4'd15, 4'd15, TOP_Y,     16'h0000, 0);
    send_beat(CMD_WRITE_DIRTY,  4'd15, 4'd15, TOP_Y + 1, 16'h0001, 0);
    send_beat(CMD_WRITE_DIRTY,  4'd15, 4'd15, MIN_Y - 1, 16'h0001, 0);
    send_beat(CMD_WRITE_SILENT, 4'd0,  4'd15, -2048,     16'hFFFF, 0);
    send_beat(CMD_WRITE_SILENT, 4'd15, 4'd0,  2047,      16'hFFFF, 0);
    send_beat(CMD_READ_CELL,    4'd15, 4'd15, -2048,     16'h0000, 0);
    send_beat(CMD_READ_CELL,    4'd15, 4'd15, 2047,      16'h0000, 0);
    send_beat(CMD_WRITE_DIRTY,  4'd15, 4'd15, TOP_Y,     16'h0000, 0);
    send_beat(CMD_SPARE_LO,     4'd3,  4'd5,  MIN_Y,     16'h5555, 0);
    send_beat(CMD_SPARE_LO + 3'd1, 4'd3, 4'd5, MIN_Y,    16'hAAAA, 0);
    send_beat(CMD_SPARE_HI,     4'd15, 4'd15, TOP_Y,     16'hFFFF, 0);
    send_beat(CMD_READ_HEIGHT,  4'd15, 4'd15, 0,         16'h0000, 0);
    send_beat(CMD_CLEAR_DIRTY,  4'd0,  4'd0,  0,         16'h0000, 0);

    // a few hot columns keep heights low so top removals and scans come often
    for (n = 0; n < 3; n++) begin
      hot_x[n] = 4'($urandom);
      hot_z[n] = 4'($urandom);
    end

    for (n = 0; n < RANDOM_BEATS; n++) begin
      roll = $urandom_range(99, 0);
      if (roll < 35)      op = CMD_WRITE_DIRTY;
      else if (roll < 60) op = CMD_WRITE_SILENT;
      else if (roll < 75) op = CMD_READ_CELL;
      else if (roll < 85) op = CMD_READ_HEIGHT;
      else if (roll < 93) op = CMD_CLEAR_DIRTY;
      else                op = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));

      if ($urandom_range(9, 0) < 7) begin
        roll = $urandom_range(2, 0);
        cx = hot_x[roll];
        cz = hot_z[roll];
      end else begin
        cx = 4'($urandom);
        cz = 4'($urandom);
      end

      roll = $urandom_range(99, 0);
      if (roll < 75)      cy = MIN_Y + $urandom_range(23, 0);
      else if (roll < 85) cy = MIN_Y + $urandom_range(COLUMN_CELLS - 1, 0);
      else if (roll < 95) cy = int'($signed(12'($urandom)));
      else begin
        case ($urandom_range(5, 0))
          0:       cy = MIN_Y - 1;
          1:       cy = MIN_Y;
          2:       cy = TOP_Y;
          3:       cy = TOP_Y + 1;
          4:       cy = -2048;
          default: cy = 2047;
        endcase
      end

      roll = $urandom_range(99, 0);
      if (roll < 40)      sid = 16'h0000;
      else if (roll < 80) sid = 16'($urandom_range(3, 1));
      else                sid = 16'($urandom);

      // back-to-back stretch every 64 beats, otherwise mostly short gaps
      roll = $urandom_range(99, 0);
      if (n % 64 < 16)    gap = 0;
      else if (roll < 60) gap = 0;
      else if (roll < 92) gap = $urandom_range(4, 1);
      else                gap = $urandom_range(150, 20);

      send_beat(op, cx, cz, cy, sid, gap);
    end
    start <= 1'b0;

    waited = 0;
    while (pending_beats != 0 && waited < WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_beats != 0)
      $error("%0d results never arrived", pending_beats);
    if (mismatch_count == 0 && pending_beats == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/vcsh_pkg.sv
hdl/vcsh_ctrl.sv
hdl/vcsh_datapath.sv
hdl/voxel_column_store_heightmap.sv
hdl/vcsh_check.sv
dv/voxel_result_checker.sv
dv/tb_top.sv
